>>> rtl/rte_pkg.sv
package rte_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic       err;
    logic       eos;
    logic       a_valid;
    logic [7:0] a_byte;
    logic       b_valid;
    logic [7:0] b_byte;
  } rte_cmd_t;

endpackage

>>> rtl/rle_text_encoder.sv
// Run-length text encoder with ASCII decimal counts.
// Path: results pass the command queue, then cmd_r, then the output register.
// Throughput: one input transfer per cycle while the output keeps up; the output
// side sends one byte per cycle while out_tready is high, up to COUNT_DIGITS+1
// bytes per run, with a four-entry command queue absorbing digit bursts.
// Reset: synchronous, active low; clears the open run, the queue and the output stage.
module rle_text_encoder
  import rte_pkg::*;
#(
  parameter int COUNT_DIGITS = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [0] digit_error, [1] stream_done
);

  localparam int COUNT_W = 4 * COUNT_DIGITS;
  localparam int Q_W     = $bits(rte_cmd_t) + COUNT_W;

  logic               push;
  rte_cmd_t           push_cmd;
  logic [COUNT_W-1:0] push_cnt;
  logic               q_pop, q_nonempty, q_full;
  logic [Q_W-1:0]     q_head;
  rte_cmd_t           q_cmd;
  logic [COUNT_W-1:0] q_cnt;

  assign in_tready = !q_full;
  assign q_cmd     = q_head[Q_W-1:COUNT_W];
  assign q_cnt     = q_head[COUNT_W-1:0];

  rte_front #(
    .COUNT_DIGITS(COUNT_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .push     (push),
    .push_cmd (push_cmd),
    .push_cnt (push_cnt)
  );

  rte_queue #(
    .W(Q_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_cmd, push_cnt}),
    .pop      (q_pop),
    .head_data(q_head),
    .nonempty (q_nonempty),
    .full     (q_full)
  );

  rte_back #(
    .COUNT_DIGITS(COUNT_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nonempty(q_nonempty),
    .q_cmd     (q_cmd),
    .q_cnt     (q_cnt),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

>>> rtl/rte_front.sv
module rte_front
  import rte_pkg::*;
#(
  parameter int COUNT_DIGITS = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [7:0]                in_tdata,
  input  logic                      in_tlast,
  output logic                      push,
  output rte_cmd_t                  push_cmd,
  output logic [4*COUNT_DIGITS-1:0] push_cnt
);

  localparam int COUNT_W = 4 * COUNT_DIGITS;

  logic [7:0]         run_byte_r, run_byte_nxt;
  logic [COUNT_W-1:0] run_count_r, run_count_nxt;
  logic               run_open_r, run_open_nxt;

  logic               accept;
  logic               is_digit;
  logic               same;
  logic [COUNT_W-1:0] cnt_inc;
  logic               inc_max;

  function automatic logic [COUNT_W-1:0] bcd_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    logic               carry;
    logic [3:0]         dig;
    r     = v;
    carry = 1'b1;
    for (int d = 0; d < COUNT_DIGITS; d++) begin
      dig = v[4*d +: 4];
      if (carry) begin
        if (dig == 4'd9) begin
          r[4*d +: 4] = 4'd0;
        end else begin
          r[4*d +: 4] = dig + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic logic bcd_is_max(input logic [COUNT_W-1:0] v);
    logic m;
    m = 1'b1;
    for (int d = 0; d < COUNT_DIGITS; d++) begin
      if (v[4*d +: 4] != 4'd9) begin
        m = 1'b0;
      end
    end
    return m;
  endfunction

  assign accept   = in_tvalid && in_tready;
  assign is_digit = (in_tdata inside {[8'h30:8'h39]});
  assign same     = run_open_r && (in_tdata == run_byte_r);
  assign cnt_inc  = bcd_inc(run_count_r);
  assign inc_max  = bcd_is_max(cnt_inc);

  always_comb begin
    run_byte_nxt  = run_byte_r;
    run_count_nxt = run_count_r;
    run_open_nxt  = run_open_r;
    push          = 1'b0;
    push_cmd      = '0;
    push_cnt      = run_count_r;
    if (accept) begin
      push_cmd.eos = in_tlast;
      if (is_digit) begin
        push_cmd.err  = 1'b1;
        push          = 1'b1;
        run_byte_nxt  = '0;
        run_count_nxt = '0;
        run_open_nxt  = 1'b0;
      end else if (same) begin
        if (inc_max || in_tlast) begin
          push             = 1'b1;
          push_cmd.a_valid = 1'b1;
          push_cmd.a_byte  = run_byte_r;
          push_cnt         = cnt_inc;
          run_count_nxt    = '0;
          run_open_nxt     = 1'b0;
        end else begin
          run_count_nxt = cnt_inc;
        end
      end else begin
        push_cmd.a_valid = run_open_r;
        push_cmd.a_byte  = run_byte_r;
        run_byte_nxt     = in_tdata;
        push             = run_open_r || in_tlast;
        if (in_tlast) begin
          push_cmd.b_valid = 1'b1;
          push_cmd.b_byte  = in_tdata;
          run_count_nxt    = '0;
          run_open_nxt     = 1'b0;
        end else begin
          run_count_nxt = COUNT_W'(1);
          run_open_nxt  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_byte_r  <= '0;
      run_count_r <= '0;
      run_open_r  <= 1'b0;
    end else begin
      run_byte_r  <= run_byte_nxt;
      run_count_r <= run_count_nxt;
      run_open_r  <= run_open_nxt;
    end
  end

endmodule

>>> rtl/rte_queue.sv
module rte_queue
  import rte_pkg::*;
#(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head_data,
  output logic         nonempty,
  output logic         full
);

  logic [W-1:0]    mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   fill_r;

  logic do_push;
  logic do_pop;

  assign full      = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign nonempty  = (fill_r != '0);
  assign head_data = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/rte_back.sv
module rte_back
  import rte_pkg::*;
#(
  parameter int COUNT_DIGITS = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_nonempty,
  input  rte_cmd_t                  q_cmd,
  input  logic [4*COUNT_DIGITS-1:0] q_cnt,
  output logic                      q_pop,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,
  output logic                      out_tlast,
  output logic [1:0]                out_tuser
);

  localparam int COUNT_W = 4 * COUNT_DIGITS;
  localparam int IDX_W   = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

  localparam logic [1:0] ST_ERR    = 2'd0;
  localparam logic [1:0] ST_DIG    = 2'd1;
  localparam logic [1:0] ST_BYTE_A = 2'd2;
  localparam logic [1:0] ST_BYTE_B = 2'd3;

  logic               cur_v_r, cur_v_nxt;
  logic [1:0]         stage_r, stage_nxt;
  logic [IDX_W-1:0]   dig_r, dig_nxt;
  rte_cmd_t           cmd_r;
  logic [COUNT_W-1:0] cnt_r;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r;
  logic               out_err_r, out_last_r, out_done_r;

  logic               adv, emit, load, cur_last;
  logic [3:0]         cur_digit;
  logic [7:0]         cur_byte;
  logic [IDX_W-1:0]   msd;
  logic [1:0]         init_stage;

  assign adv       = !out_valid_r || out_tready;
  assign emit      = cur_v_r && adv;
  assign cur_digit = 4'(cnt_r >> {dig_r, 2'b00});

  always_comb begin
    cur_last = 1'b0;
    cur_byte = '0;
    case (stage_r)
      ST_ERR: begin
        cur_last = 1'b1;
        cur_byte = '0;
      end
      ST_DIG: begin
        cur_last = 1'b0;
        cur_byte = 8'h30 + {4'd0, cur_digit};
      end
      ST_BYTE_A: begin
        cur_last = !cmd_r.b_valid;
        cur_byte = cmd_r.a_byte;
      end
      ST_BYTE_B: begin
        cur_last = 1'b1;
        cur_byte = cmd_r.b_byte;
      end
      default: begin
        cur_last = 1'b1;
        cur_byte = '0;
      end
    endcase
  end

  assign load  = q_nonempty && (!cur_v_r || (emit && cur_last));
  assign q_pop = load;

  always_comb begin
    msd = '0;
    for (int d = 0; d < COUNT_DIGITS; d++) begin
      if (q_cnt[4*d +: 4] != 4'd0) begin
        msd = IDX_W'(d);
      end
    end
  end

  always_comb begin
    if (q_cmd.err) begin
      init_stage = ST_ERR;
    end else if (q_cmd.a_valid) begin
      init_stage = (q_cnt == COUNT_W'(1)) ? ST_BYTE_A : ST_DIG;
    end else begin
      init_stage = ST_BYTE_B;
    end
  end

  always_comb begin
    cur_v_nxt     = cur_v_r;
    stage_nxt     = stage_r;
    dig_nxt       = dig_r;
    out_valid_nxt = adv ? emit : out_valid_r;
    if (load) begin
      cur_v_nxt = 1'b1;
      stage_nxt = init_stage;
      dig_nxt   = msd;
    end else if (emit) begin
      if (cur_last) begin
        cur_v_nxt = 1'b0;
      end else if (stage_r == ST_DIG) begin
        if (dig_r == '0) begin
          stage_nxt = ST_BYTE_A;
        end else begin
          dig_nxt = dig_r - 1'b1;
        end
      end else begin
        stage_nxt = ST_BYTE_B;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      stage_r     <= ST_ERR;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_v_r     <= cur_v_nxt;
      stage_r     <= stage_nxt;
      dig_r       <= dig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= q_cmd;
      cnt_r <= q_cnt;
    end
    if (emit) begin
      out_byte_r <= cur_byte;
      out_err_r  <= (stage_r == ST_ERR);
      out_last_r <= cur_last;
      out_done_r <= cur_last && (cmd_r.eos || cmd_r.err);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_done_r, out_err_r};

endmodule
